// ===== rtl/jbp_pkg.sv =====
// ----------------------------------------------------------------------------
// jbp_pkg
// Shared constants and types for the entropy bit packer with byte stuffing.
// ----------------------------------------------------------------------------
package jbp_pkg;

    // operation codes on the input channel
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // largest code length taken by a write, longer counts saturate
    localparam int MAX_WRITE_BITS = 32;

    // field widths
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 6;
    localparam int BYTE_W  = 8;

    // bits left over between items, at most one byte less one bit
    localparam int PEND_W = BYTE_W - 1;

    // accumulator holds the leftover bits and one full write
    localparam int ACC_W = PEND_W + MAX_WRITE_BITS;

    localparam logic [CNT_W-1:0]  WRITE_CNT_MAX = CNT_W'(MAX_WRITE_BITS);
    localparam logic [CNT_W-1:0]  BYTE_CNT      = CNT_W'(BYTE_W);
    localparam logic [BYTE_W-1:0] STUFF_MARK    = 8'hFF;
    localparam logic [BYTE_W-1:0] STUFF_FILL    = 8'h00;

    // result of the shared byte extractor
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  rem;
    } shift_res_t;

endpackage

// ===== rtl/jbp_in_if.sv =====
// ----------------------------------------------------------------------------
// jbp_in_if
// Input channel: write or flush commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jbp_in_if;

    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [jbp_pkg::VALUE_W-1:0]         bits_value;
    logic [jbp_pkg::CNT_W-1:0]           bit_count;

    modport source (output valid, output func, output bits_value, output bit_count,
                    input ready);
    modport sink   (input valid, input func, input bits_value, input bit_count,
                    output ready);

endinterface

// ===== rtl/jbp_out_if.sv =====
// ----------------------------------------------------------------------------
// jbp_out_if
// Output channel: stuffed byte stream with a last marker per command.
// ----------------------------------------------------------------------------
interface jbp_out_if;

    logic                                valid;
    logic                                ready;
    logic [jbp_pkg::BYTE_W-1:0]          out_byte;
    logic                                last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);

endinterface

// ===== rtl/jbp_shift_unit.sv =====
// ----------------------------------------------------------------------------
// jbp_shift_unit
// Shared byte extractor: takes the top complete byte of the accumulator.
// ----------------------------------------------------------------------------
module jbp_shift_unit (
    input  logic [jbp_pkg::ACC_W-1:0] acc,
    input  logic [jbp_pkg::CNT_W-1:0] cnt,
    output jbp_pkg::shift_res_t       res
);

    logic [jbp_pkg::CNT_W-1:0] rem;

    // bits that stay behind once the top byte is taken
    assign rem = cnt - jbp_pkg::BYTE_CNT;

    // right shift brings the top byte down to the low end
    always_comb
    begin
        res.rem  = rem;
        res.data = jbp_pkg::BYTE_W'(acc >> rem);
    end

endmodule

// ===== rtl/jbp_bit_packer.sv =====
// ----------------------------------------------------------------------------
// jpeg_bit_packer_stuffing
// Packs variable-length codes MSB first into a byte stream with 0xFF stuffing.
// ----------------------------------------------------------------------------
//  channel  | dir | word                        | handshake
//  in_ch    | in  | func, bits_value, bit_count | valid/ready
//  out_ch   | out | out_byte, last              | valid/ready
//
//  a write is loaded while idle, then the single shared byte extractor gives
//  one output word per cycle unless the output stalls, stuffed zero words
//  included, up to 8 words for 32 bits; a flush with pending bits gives one
//  padded word, one with none or a zero-length write gives no word
//  input ready only while the sequencer is idle; output register decouples
//  a stalled output holds the sequencer; reset clears all pending bits
// ----------------------------------------------------------------------------
module jpeg_bit_packer_stuffing (
    input  logic      clk,
    input  logic      rst_n,
    jbp_in_if.sink    in_ch,
    jbp_out_if.source out_ch
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_STUFF = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [jbp_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [jbp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             out_valid_reg;
    logic [jbp_pkg::BYTE_W-1:0]       out_byte_reg;
    logic                             out_last_reg;

    logic                             slot_free;
    logic                             load;
    logic [jbp_pkg::BYTE_W-1:0]       load_data;
    logic                             load_last;

    logic [jbp_pkg::CNT_W-1:0]        cnt_sat;
    logic [jbp_pkg::VALUE_W-1:0]      val_mask;
    logic [jbp_pkg::PEND_W-1:0]       pend;
    logic [2:0]                       pend_cnt;
    logic [3:0]                       pad_sh;
    logic [jbp_pkg::BYTE_W-1:0]       pad_byte;
    logic [jbp_pkg::CNT_W-1:0]        cnt_sum;
    logic [jbp_pkg::ACC_W-1:0]        acc_write;

    jbp_pkg::shift_res_t              sres;

    // shared byte extractor
    jbp_shift_unit u_shift (
        .acc (acc_reg),
        .cnt (cnt_reg),
        .res (sres)
    );

    // leftover bits and write operand preparation
    always_comb
    begin
        pend_cnt = cnt_reg[2:0];
        pend     = acc_reg[jbp_pkg::PEND_W-1:0] & ~({jbp_pkg::PEND_W{1'b1}} << pend_cnt);
        pad_sh   = 4'd8 - {1'b0, pend_cnt};
        pad_byte = jbp_pkg::BYTE_W'({1'b0, pend} << pad_sh);
        cnt_sat  = (in_ch.bit_count > jbp_pkg::WRITE_CNT_MAX) ? jbp_pkg::WRITE_CNT_MAX
                                                               : in_ch.bit_count;
        val_mask = ~({jbp_pkg::VALUE_W{1'b1}} << cnt_sat);
        cnt_sum  = {3'b000, pend_cnt} + cnt_sat;
        acc_write = (jbp_pkg::ACC_W'(pend) << cnt_sat)
                  | jbp_pkg::ACC_W'(in_ch.bits_value & val_mask);
    end

    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        load       = 1'b0;
        load_data  = jbp_pkg::STUFF_FILL;
        load_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.func == jbp_pkg::FUNC_FLUSH)
                    begin
                        acc_next = jbp_pkg::ACC_W'(pad_byte);
                        if (pend_cnt != 3'd0)
                        begin
                            cnt_next   = jbp_pkg::BYTE_CNT;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cnt_next = '0;
                        end
                    end
                    else if (cnt_sat != '0)
                    begin
                        acc_next = acc_write;
                        cnt_next = cnt_sum;
                        if (cnt_sum >= jbp_pkg::BYTE_CNT)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_data = sres.data;
                    cnt_next  = sres.rem;
                    if (sres.data == jbp_pkg::STUFF_MARK)
                    begin
                        state_next = ST_STUFF;
                    end
                    else if (sres.rem < jbp_pkg::BYTE_CNT)
                    begin
                        load_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STUFF:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_data = jbp_pkg::STUFF_FILL;
                    load_last = (cnt_reg < jbp_pkg::BYTE_CNT);
                    state_next = load_last ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= load_data;
            out_last_reg <= load_last;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

`ifndef SYNTHESIS
    // between items less than a byte is left over
    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg < jbp_pkg::BYTE_CNT))
        else $error("idle with a complete byte pending");

    // a byte is only extracted when one is complete
    a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg >= jbp_pkg::BYTE_CNT))
        else $error("emit state without a complete byte");

    // the word after a stuff step is the zero fill
    a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STUFF && slot_free) |=> (out_byte_reg == jbp_pkg::STUFF_FILL))
        else $error("stuffed word is not zero");

    // a marker byte is never the last word
    a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_data == jbp_pkg::STUFF_MARK) |-> !load_last)
        else $error("0xff word flagged last");

    // the last word returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |=> (state_reg == ST_IDLE))
        else $error("last word without return to idle");
`endif

endmodule

// ===== dv/tb_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sb_pkg
// Scoreboard for the bit packer: keeps its own bit accumulator, works out the
// stuffed bytes that each accepted command must produce and checks every
// output word against the oldest one still outstanding.
// ----------------------------------------------------------------------------
package tb_sb_pkg;

    import jbp_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_word_t;

    class packer_scoreboard;

        byte_word_t  expected_bytes[$];
        logic [6:0]  acc_bits;
        int unsigned acc_cnt;
        int unsigned mismatch_count;

        function new();
            acc_bits       = '0;
            acc_cnt        = 0;
            mismatch_count = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatch_count++;
        endtask

        // queue one byte, plus the inserted zero after a marker byte
        function void queue_byte(logic [BYTE_W-1:0] b);
            byte_word_t w;
            w.data = b;
            w.last = 1'b0;
            expected_bytes.push_back(w);
            if (b == STUFF_MARK)
            begin
                w.data = STUFF_FILL;
                expected_bytes.push_back(w);
            end
        endfunction

        // accepted command: advance the accumulator, queue the bytes it completes
        function void note_word(logic func, logic [VALUE_W-1:0] value,
                                logic [CNT_W-1:0] count);
            int unsigned     n_before;
            int unsigned     cnt;
            int unsigned     total;
            logic [31:0]     vmask;
            logic [ACC_W-1:0] acc;
            n_before = expected_bytes.size();
            if (func == FUNC_FLUSH)
            begin
                if (acc_cnt != 0)
                    queue_byte(BYTE_W'({1'b0, acc_bits} << (8 - acc_cnt)));
                acc_bits = '0;
                acc_cnt  = 0;
            end
            else
            begin
                cnt = (count > WRITE_CNT_MAX) ? MAX_WRITE_BITS : int'(count);
                if (cnt != 0)
                begin
                    vmask = (cnt == 32) ? 32'hFFFF_FFFF : ((32'h1 << cnt) - 32'h1);
                    acc   = (ACC_W'(acc_bits) << cnt) | ACC_W'(value & vmask);
                    total = acc_cnt + cnt;
                    while (total >= 8)
                    begin
                        queue_byte(BYTE_W'(acc >> (total - 8)));
                        total -= 8;
                    end
                    acc      = acc & ((ACC_W'(1) << total) - ACC_W'(1));
                    acc_bits = acc[6:0];
                    acc_cnt  = total;
                end
            end
            // mark the final byte of this command
            if (expected_bytes.size() > n_before)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        // accepted output word against the oldest expectation
        task check_word(logic [BYTE_W-1:0] data, logic last);
            byte_word_t w;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected word byte=%02h last=%0b", data, last));
                return;
            end
            w = expected_bytes.pop_front();
            if (data !== w.data)
                report($sformatf("out_byte got %02h want %02h", data, w.data));
            if (last !== w.last)
                report($sformatf("last got %0b want %0b (byte %02h)", last, w.last,
                                 w.data));
        endtask

        function bit busy();
            return expected_bytes.size() != 0;
        endfunction

        // anything still outstanding at the end is a failure
        task drain_check();
            foreach (expected_bytes[i])
                report($sformatf("missing word byte=%02h last=%0b",
                                 expected_bytes[i].data, expected_bytes[i].last));
            expected_bytes.delete();
        endtask

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives write and flush commands into the bit packer with random idle and
// stall bursts on both channels, and checks the stuffed byte stream and its
// last markers through the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import jbp_pkg::*;
    import tb_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 450;
    localparam int CALM_FROM      = 370;
    localparam int TAIL_CYCLES    = 20;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_cycles;

    jbp_in_if  in_ch();
    jbp_out_if out_ch();

    packer_scoreboard sb = new();

    jpeg_bit_packer_stuffing i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // note accepted commands and check accepted output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_word(in_ch.func, in_ch.bits_value, in_ch.bit_count);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.out_byte, out_ch.last);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("jpeg_bit_packer_stuffing test failed");
            $finish;
        end
    end

    // output ready with random stall bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // present one command and hold it until accepted
    task automatic send_word(logic func, logic [VALUE_W-1:0] value,
                             logic [CNT_W-1:0] count);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.bits_value <= value;
        in_ch.bit_count  <= count;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    // hold the input off until every expected byte has come out
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        // wait for the clock so the last accepted command is already noted
        @(posedge clk);
        while (sb.busy() && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // one random command, mostly writes with a bias towards marker bytes
    task automatic send_random();
        int               r;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   count;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2: value = 32'hFFFF_FFFF;
            3:       value = '0;
            default: value = $urandom;
        endcase
        if (r < 30)
            count = CNT_W'($urandom_range(1, 8));
        else if (r < 80)
            count = CNT_W'($urandom_range(1, 32));
        else if (r < 86)
            count = CNT_W'($urandom_range(33, 63));
        else
            count = '0;
        if ($urandom_range(0, 99) < 12)
            send_word(FUNC_FLUSH, $urandom, CNT_W'($urandom));
        else
            send_word(FUNC_WRITE, value, count);
    endtask

    initial
    begin
        int guard;
        rst_n            <= 1'b0;
        idle_pct         = 0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_WRITE;
        in_ch.bits_value <= '0;
        in_ch.bit_count  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases
        idle_pct = 20;
        send_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd32);
        send_word(FUNC_WRITE, 32'hDEAD_BEEF, 6'd0);
        send_word(FUNC_FLUSH, 32'h0, 6'd0);
        send_word(FUNC_WRITE, 32'h1, 6'd1);
        send_word(FUNC_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send_word(FUNC_WRITE, 32'h7F, 6'd7);
        send_word(FUNC_FLUSH, $urandom, 6'd17);
        send_word(FUNC_WRITE, 32'hF, 6'd4);
        send_word(FUNC_WRITE, 32'hF, 6'd4);
        send_word(FUNC_WRITE, 32'hA5A5_A5A5, 6'd63);
        send_word(FUNC_WRITE, 32'h1234_5678, 6'd33);
        send_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd3);
        send_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd13);
        send_word(FUNC_WRITE, 32'h0, 6'd5);
        send_word(FUNC_WRITE, 32'h0, 6'd32);
        send_word(FUNC_FLUSH, 32'h0, 6'd0);
        send_word(FUNC_WRITE, 32'hFF, 6'd8);
        send_word(FUNC_WRITE, 32'h8000_0001, 6'd31);
        send_word(FUNC_WRITE, 32'hFFFF_FFFF, 6'd40);
        send_word(FUNC_FLUSH, $urandom, 6'd32);
        send_word(FUNC_FLUSH, 32'h0, 6'd0);
        wait_drained();

        // random commands, idling rate changes per stretch
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (i >= CALM_FROM)
                idle_pct = 0;
            if (i == N_RANDOM / 2)
                wait_drained();
            send_random();
        end
        in_ch.valid <= 1'b0;

        // let the stream drain, then a short tail
        guard = 0;
        while (sb.busy() && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.drain_check();

        if (sb.mismatch_count == 0)
            $display("jpeg_bit_packer_stuffing test passed");
        else
            $display("jpeg_bit_packer_stuffing test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jbp_pkg.sv
rtl/jbp_in_if.sv
rtl/jbp_out_if.sv
rtl/jbp_shift_unit.sv
rtl/jbp_bit_packer.sv
dv/tb_sb_pkg.sv
dv/tb_top.sv
